/* sv/msps_pkg.sv */
// Package with the types and constants shared by the periodic flag scheduler.
`timescale 1ns / 1ps
`default_nettype none

package msps_pkg;

  localparam int unsigned Slots        = 8;
  localparam int unsigned SlotIdxW     = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned PeriodW      = 8;
  localparam int unsigned CountW       = 8;
  localparam int unsigned DivisorW     = 8;
  localparam int unsigned SlotIndexW   = 3;
  localparam int unsigned FiredMaskW   = 8;
  localparam int unsigned MaskKeepW    = (Slots < FiredMaskW) ? Slots : FiredMaskW;
  localparam logic [DivisorW-1:0] DivisorReset = DivisorW'(11);

  localparam logic CmdTick   = 1'b0;
  localparam logic CmdAttach = 1'b1;

  typedef struct packed {
    logic               command;
    logic [PeriodW-1:0] attach_period;
  } in_t;

  typedef struct packed {
    logic [SlotIndexW-1:0] slot_index;
    logic                  attach_status;
    logic [FiredMaskW-1:0] fired_mask;
    logic                  divided_tick;
    logic                  heartbeat;
  } out_t;

  // Update strobes from the top level to the slot bank.
  typedef struct packed {
    logic               attach;
    logic               divided;
    logic [PeriodW-1:0] period;
  } slot_ctl_t;

  // Status from the slot bank, valid from its current state.
  typedef struct packed {
    logic                full;
    logic [SlotIdxW-1:0] free_idx;
    logic [Slots-1:0]    fire;
  } slot_sts_t;

endpackage

`default_nettype wire

/* sv/multi_slot_periodic_flag_scheduler.sv */
// Top level of the multi-slot periodic flag scheduler with prescaler and output skid buffer.
`timescale 1ns / 1ps
`default_nettype none

// One transaction per clock while in_stall_o is low: an attach claims the lowest free slot, a
// raw tick advances the prescaler and, when it wraps at the divisor, toggles the heartbeat and
// steps every used slot counter in parallel, reporting the slots that fired. Each input
// transaction produces one registered result transaction, and items may enter every cycle while
// in_stall_o is low. The result leaves through an output register backed by a one-entry skid
// register, so one further transaction is accepted while a result is stalled; in_stall_o rises
// only when both are full. The divisor register resets to 11 and should be written only while the block is idle.
module multi_slot_periodic_flag_scheduler (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire [7:0]          cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire msps_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output msps_pkg::out_t     out_data_o
);
  import msps_pkg::*;

  logic [DivisorW-1:0] divisor_q;
  logic [DivisorW-1:0] pre_count_q, pre_count_d;
  logic                hb_q, hb_d;
  logic [DivisorW:0]   pre_inc;
  logic                wrap;
  logic                accept;
  logic                is_attach;
  out_t                res;
  slot_ctl_t           slot_ctl;
  slot_sts_t           slot_sts;

  logic                out_valid_q, skid_valid_q;
  out_t                out_q, skid_q;
  logic                out_take;

  assign accept    = in_valid_i && !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign is_attach = (in_data_i.command == CmdAttach);

  assign pre_inc = {1'b0, pre_count_q} + (DivisorW + 1)'(1);
  assign wrap    = (pre_inc >= {1'b0, divisor_q});

  always_comb begin
    pre_count_d = pre_count_q;
    hb_d        = hb_q;
    if (accept && !is_attach) begin
      if (wrap) begin
        pre_count_d = '0;
        hb_d        = !hb_q;
      end else begin
        pre_count_d = pre_inc[DivisorW-1:0];
      end
    end
  end

  assign slot_ctl.attach  = accept && is_attach;
  assign slot_ctl.divided = accept && !is_attach && wrap;
  assign slot_ctl.period  = in_data_i.attach_period;

  msps_slot_bank u_slot_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (slot_ctl),
    .sts_o  (slot_sts)
  );

  always_comb begin
    res = '0;
    res.heartbeat = hb_d;
    if (is_attach) begin
      res.attach_status = slot_sts.full;
      if (!slot_sts.full) begin
        res.slot_index = SlotIndexW'(slot_sts.free_idx);
      end
    end else if (wrap) begin
      res.divided_tick = 1'b1;
      res.fired_mask   = FiredMaskW'(slot_sts.fire[MaskKeepW-1:0]);
    end
  end

  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q    <= DivisorReset;
      pre_count_q  <= '0;
      hb_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        divisor_q <= cfg_wdata_i;
      end
      pre_count_q <= pre_count_d;
      hb_q        <= hb_d;
      if (skid_valid_q) begin
        // The skid entry moves up once the output register drains.
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid_q || out_take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // The skid register only fills behind a waiting output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

  // An accepted transaction always leaves a result pending in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted transaction produced no result");

  // The heartbeat moves only on a divided tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !slot_ctl.divided |=> (hb_q == $past(hb_q)))
    else $error("heartbeat toggled without a divided tick");

  // A tick that does not wrap advances the prescaler by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_attach && !wrap) |=> (pre_count_q == $past(pre_inc[DivisorW-1:0])))
    else $error("prescaler did not advance");
`endif

endmodule

`default_nettype wire

/* sv/msps_slot_bank.sv */
// Slot bank: used bits, periods and counters of all slots, with the free-slot search.
`timescale 1ns / 1ps
`default_nettype none

module msps_slot_bank (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire msps_pkg::slot_ctl_t ctl_i,
  output msps_pkg::slot_sts_t      sts_o
);
  import msps_pkg::*;

  logic [Slots-1:0]   used_q, used_d;
  logic [PeriodW-1:0] period_q [Slots];
  logic [CountW-1:0]  count_q  [Slots];
  logic [PeriodW-1:0] period_d [Slots];
  logic [CountW-1:0]  count_d  [Slots];
  logic [Slots-1:0]   fire;
  logic [CountW:0]    count_inc [Slots];
  logic               full;
  logic [SlotIdxW-1:0] free_idx;

  // Lowest free slot wins; scanning downward leaves the lowest one last.
  always_comb begin
    full     = 1'b1;
    free_idx = '0;
    for (int s = Slots - 1; s >= 0; s--) begin
      if (!used_q[s]) begin
        full     = 1'b0;
        free_idx = SlotIdxW'(s);
      end
    end
  end

  always_comb begin
    for (int s = 0; s < Slots; s++) begin
      count_inc[s] = {1'b0, count_q[s]} + (CountW + 1)'(1);
      fire[s]      = used_q[s] && (count_inc[s] >= {1'b0, period_q[s]});
    end
  end

  always_comb begin
    used_d = used_q;
    for (int s = 0; s < Slots; s++) begin
      period_d[s] = period_q[s];
      count_d[s]  = count_q[s];
      if (ctl_i.divided && used_q[s]) begin
        count_d[s] = fire[s] ? '0 : count_inc[s][CountW-1:0];
      end
      if (ctl_i.attach && !full && (free_idx == SlotIdxW'(s))) begin
        used_d[s]   = 1'b1;
        period_d[s] = ctl_i.period;
        count_d[s]  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      for (int s = 0; s < Slots; s++) begin
        period_q[s] <= '0;
        count_q[s]  <= '0;
      end
    end else begin
      used_q <= used_d;
      for (int s = 0; s < Slots; s++) begin
        period_q[s] <= period_d[s];
        count_q[s]  <= count_d[s];
      end
    end
  end

  assign sts_o.full     = full;
  assign sts_o.free_idx = free_idx;
  assign sts_o.fire     = fire;

`ifndef NO_ASSERTIONS
  // A successful attach marks its slot as used.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.attach && !full) |=> used_q[$past(free_idx)])
    else $error("attached slot not marked used");

  // Slots never get released, so the used set only grows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((used_q & $past(used_q)) == $past(used_q)))
    else $error("used slot was released");

  // Only used slots can fire.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire & ~used_q) == '0)
    else $error("unused slot fires");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the multi-slot periodic flag scheduler.
`timescale 1ns / 1ps

module tb_top;
  import msps_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int NumPhases = 9;

  // Tracks the scheduler state and the results it should produce, in order.
  class sched_tracker;
    logic [DivisorW-1:0] divisor;
    logic [DivisorW-1:0] prescale_count;
    logic                heartbeat;
    logic [Slots-1:0]    used;
    logic [PeriodW-1:0]  period [Slots];
    logic [CountW-1:0]   count [Slots];
    out_t                expected_q [$];
    int unsigned         mismatches;
    int unsigned         checked;
    int unsigned         divided_seen;
    int unsigned         full_seen;
    int unsigned         fired_seen;

    function new();
      divisor        = DivisorReset;
      prescale_count = '0;
      heartbeat      = 1'b0;
      used           = '0;
      for (int s = 0; s < Slots; s++) begin
        period[s] = '0;
        count[s]  = '0;
      end
      mismatches   = 0;
      checked      = 0;
      divided_seen = 0;
      full_seen    = 0;
      fired_seen   = 0;
    endfunction

    function void set_divisor(logic [DivisorW-1:0] value);
      divisor = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Advances the state by one accepted input transaction and queues its result.
    function void note_item(in_t item);
      out_t             res;
      int               free_slot;
      logic [DivisorW:0] next;
      logic [CountW:0]   c;
      res = '0;
      if (item.command == CmdAttach) begin
        free_slot = -1;
        for (int s = 0; s < Slots; s++) begin
          if (!used[s] && free_slot < 0) free_slot = s;
        end
        if (free_slot < 0) begin
          res.attach_status = 1'b1;
          full_seen++;
        end else begin
          used[free_slot]   = 1'b1;
          period[free_slot] = item.attach_period;
          count[free_slot]  = '0;
          res.slot_index    = SlotIndexW'(free_slot);
        end
      end else begin
        next = {1'b0, prescale_count} + 1'b1;
        // The compare is >=, so a divisor lowered below the count wraps at once.
        if (next >= {1'b0, divisor}) begin
          prescale_count   = '0;
          heartbeat        = ~heartbeat;
          res.divided_tick = 1'b1;
          divided_seen++;
          for (int s = 0; s < Slots; s++) begin
            if (used[s]) begin
              c = {1'b0, count[s]} + 1'b1;
              if (c >= {1'b0, period[s]}) begin
                count[s] = '0;
                if (s < FiredMaskW) res.fired_mask[s] = 1'b1;
              end else begin
                count[s] = c[CountW-1:0];
              end
            end
          end
          if (res.fired_mask != '0) fired_seen++;
        end else begin
          prescale_count = next[DivisorW-1:0];
        end
      end
      res.heartbeat = heartbeat;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected: %h", got);
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      compare_field("slot_index", exp_r.slot_index, got.slot_index);
      compare_field("attach_status", exp_r.attach_status, got.attach_status);
      compare_field("fired_mask", exp_r.fired_mask, got.fired_mask);
      compare_field("divided_tick", exp_r.divided_tick, got.divided_tick);
      compare_field("heartbeat", exp_r.heartbeat, got.heartbeat);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [DivisorW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;

  logic                in_no_idle = 1'b0;
  logic                out_no_idle = 1'b0;
  int unsigned         cycle_count = 0;
  int unsigned         items_sent = 0;
  sched_tracker        tracker;

  int unsigned phase_div [NumPhases] = '{1, 0, 255, 3, 20, 2, 0, 7, 1};
  int unsigned phase_len [NumPhases] = '{300, 150, 320, 100, 150, 100, 120, 100, 60};

  multi_slot_periodic_flag_scheduler uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, tracker.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_t make_item(logic cmd, logic [PeriodW-1:0] per);
    in_t item;
    item.command       = cmd;
    item.attach_period = per;
    return item;
  endfunction

  // Presents one input transaction after a random gap and waits until it is taken.
  task automatic send_item(input in_t item);
    int unsigned gap;
    gap = in_no_idle ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (in_stall);
    tracker.note_item(item);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [DivisorW-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    tracker.set_divisor(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_random_phase(input int unsigned n);
    logic cmd;
    for (int unsigned i = 0; i < n; i++) begin
      cmd = ($urandom_range(0, 99) < 8) ? CmdAttach : CmdTick;
      send_item(make_item(cmd, PeriodW'($urandom_range(0, 255))));
    end
  endtask

  // Result side: stall for a random number of cycles, then take one transaction.
  initial begin
    int unsigned stall_len;
    @(posedge rst_n);
    forever begin
      stall_len = out_no_idle ? 0 : $urandom_range(0, 12);
      if (stall_len > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (stall_len) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      tracker.check_result(out_data);
    end
  end

  initial begin
    tracker = new();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Ticks with no slot in use, attaches at both period extremes, a wrap at the
    // reset divisor, then filling every slot and one attach that finds them full.
    repeat (3) send_item(make_item(CmdTick, 8'hFF));
    send_item(make_item(CmdAttach, 8'd0));
    send_item(make_item(CmdAttach, 8'd255));
    send_item(make_item(CmdAttach, 8'd1));
    repeat (8) send_item(make_item(CmdTick, 8'h00));
    send_item(make_item(CmdAttach, 8'd2));
    send_item(make_item(CmdAttach, 8'd3));
    send_item(make_item(CmdAttach, 8'd5));
    send_item(make_item(CmdAttach, 8'd7));
    send_item(make_item(CmdAttach, 8'd128));
    send_item(make_item(CmdAttach, 8'd9));
    repeat (2) send_item(make_item(CmdTick, 8'h55));
    wait_drained();

    phase_div[6] = $urandom_range(1, 255);
    for (int p = 0; p < NumPhases; p++) begin
      in_no_idle  = ($urandom_range(0, 3) == 0);
      out_no_idle = ($urandom_range(0, 3) == 0);
      write_divisor(DivisorW'(phase_div[p]));
      run_random_phase(phase_len[p]);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d items and checked %0d results over %0d divisor settings.",
             items_sent, tracker.checked, NumPhases + 1);
    $display("Saw %0d divided ticks, %0d ticks with slots firing, %0d full attaches.",
             tracker.divided_seen, tracker.fired_seen, tracker.full_seen);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
